FILE: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the stereo feedback delay: frame structs,
// configuration register indexes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int SAMPLE_W = 16;   // width of the sample fields on the ports
    localparam int CFG_W    = 17;   // widest configuration register
    localparam int GAIN_W   = 17;   // Q0.16 gain, one spare bit for 1.0
    localparam int FB_W     = 16;   // feedback gain width

    localparam logic [CFG_W-1:0] DELAY_RST = 17'd4800;
    localparam logic [FB_W-1:0]  FB_RST    = 16'd32768;
    localparam logic [CFG_W-1:0] WET_RST   = 17'd32768;
    localparam logic [CFG_W-1:0] IGAIN_RST = 17'd65536;

    typedef enum logic [1:0] {
        CFG_DELAY_LENGTH  = 2'd0,
        CFG_FEEDBACK_GAIN = 2'd1,
        CFG_WET_MIX       = 2'd2,
        CFG_INPUT_GAIN    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DRY_GO,
        ST_DRY_RUN,
        ST_ECHO_GO,
        ST_ECHO_RUN,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } t_frame_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_frame_out;

endpackage

FILE: rtl/sfd_sermul.sv
// ----------------------------------------------------------------------------
// sfd_sermul
// Serial-parallel multiplier: signed sample times unsigned Q0.16 gain, one
// gain bit per cycle, low product bits shifted out into the gain register.
// Gives the product scaled down by 2^16 plus the rounding bit below it.
// ----------------------------------------------------------------------------
module sfd_sermul #(
    parameter int MW = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [MW-1:0]       i_mcand,
    input  logic [sfd_pkg::GAIN_W-1:0] i_mult,
    output logic                       o_done,
    output logic signed [MW+1:0]       o_scaled,
    output logic                       o_half
);
    import sfd_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic signed [MW-1:0] r_mcand;
    logic signed [MW:0]   r_hi;
    logic [GAIN_W-1:0]    r_lo;

    logic signed [MW+1:0] sum;
    logic signed [MW:0]   n_hi;
    logic [GAIN_W-1:0]    n_lo;

    // partial sum, then one arithmetic shift right across hi:lo
    always_comb begin
        sum  = r_lo[0] ? ((MW+2)'(r_hi) + (MW+2)'(r_mcand)) : (MW+2)'(r_hi);
        n_hi = sum[MW+1:1];
        n_lo = {sum[0], r_lo[GAIN_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_LAST;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mult;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_done   = r_done;
    assign o_scaled = $signed({r_hi, r_lo[GAIN_W-1]});
    assign o_half   = r_lo[GAIN_W-2];

endmodule

FILE: rtl/stereo_feedback_delay.sv
// ----------------------------------------------------------------------------
// stereo_feedback_delay
// Stereo feedback echo: per channel dry gain, circular delay store with
// feedback, and a dry/wet crossfade, all saturated to the sample width.
// ----------------------------------------------------------------------------
// A frame runs from transfer in to result out through the sequencer states:
// each channel runs the input-gain multiply and then the feedback and wet
// multiplies, each a serial multiplier taking one gain bit per cycle, with a
// start and a done step; one step forms the read address and one loads the
// output register. Frames are worked one at a time: a new frame is taken only
// after the last result is loaded into the output register, and may be taken
// while that result still waits there. The echo store is a single
// port-per-cycle RAM; store entries not yet written since reset read as zero
// through a wrap flag on the write pointer, so no clearing pass is needed.
// Delay values outside 1..DELAY_DEPTH-1 are clamped into that range.
// ----------------------------------------------------------------------------
module stereo_feedback_delay #(
    parameter int DELAY_DEPTH = 131072,
    parameter int SAMPLE_BITS = 16,
    parameter int CHANNELS    = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  sfd_pkg::t_cfg_idx         i_cfg_index,
    input  logic [sfd_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  sfd_pkg::t_frame_in        i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output sfd_pkg::t_frame_out       o_out_data
);
    import sfd_pkg::*;

    localparam int SB       = SAMPLE_BITS;
    localparam int NCH      = (CHANNELS > 1) ? 2 : 1;
    localparam int PW       = $clog2(DELAY_DEPTH);
    localparam int AW       = PW + NCH - 1;
    localparam int MEM_SIZE = NCH * DELAY_DEPTH;
    localparam int EW       = (PW > CFG_W) ? PW : CFG_W;
    localparam int CLW      = ((SB > SAMPLE_W) ? SB : SAMPLE_W) + 4;

    localparam logic [EW-1:0] DMAX     = EW'(DELAY_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_X  = (PW+1)'(DELAY_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(DELAY_DEPTH - 1);
    localparam logic          LAST_CH  = 1'(NCH - 1);

    localparam logic signed [CLW-1:0] SMAX = {{(CLW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [CLW-1:0] SMIN = {{(CLW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    function automatic logic signed [SB-1:0] clip_sample(input logic signed [CLW-1:0] v);
        logic signed [SB-1:0] res;
        if (v > SMAX) begin
            res = SMAX[SB-1:0];
        end else if (v < SMIN) begin
            res = SMIN[SB-1:0];
        end else begin
            res = v[SB-1:0];
        end
        return res;
    endfunction

    // configuration
    logic [CFG_W-1:0] r_delay_length;
    logic [FB_W-1:0]  r_feedback_gain;
    logic [CFG_W-1:0] r_wet_mix;
    logic [CFG_W-1:0] r_input_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length  <= DELAY_RST;
            r_feedback_gain <= FB_RST;
            r_wet_mix       <= WET_RST;
            r_input_gain    <= IGAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_data;
                CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[FB_W-1:0];
                CFG_WET_MIX:       r_wet_mix       <= i_cfg_data;
                CFG_INPUT_GAIN:    r_input_gain    <= i_cfg_data;
                default:           r_input_gain    <= r_input_gain;
            endcase
        end
    end

    // control and datapath registers
    t_state                 r_state, n_state;
    logic [PW-1:0]          r_wp;
    logic                   r_wrapped;
    logic [PW-1:0]          r_dlen;
    logic [PW-1:0]          r_rd_ptr;
    logic                   r_rd_ok;
    logic                   r_ch;
    logic signed [SAMPLE_W-1:0] r_x_l, r_x_r;
    logic signed [SB-1:0]   r_dry, r_dly;
    logic signed [SB-1:0]   r_rdata;
    logic [SAMPLE_W-1:0]    r_res_l, r_res_r;
    logic                   r_out_valid;
    t_frame_out             r_out_data;

    // sequencer strobes
    logic in_ready, addr_ld, dry_go, mem_rd, dry_ld, echo_go, mem_we, ch_next, send;

    // delay clamp, 1 .. DELAY_DEPTH-1
    logic [EW-1:0] dl_ext, dl_clamp;
    always_comb begin
        dl_ext = EW'(r_delay_length);
        if (dl_ext == '0) begin
            dl_clamp = EW'(1);
        end else if (dl_ext > DMAX) begin
            dl_clamp = DMAX;
        end else begin
            dl_clamp = dl_ext;
        end
    end

    // read pointer behind the write pointer, with wrap
    logic          ahead;
    logic [PW:0]   rd_sum;
    always_comb begin
        ahead = (r_wp >= r_dlen);
        if (ahead) begin
            rd_sum = {1'b0, r_wp} - {1'b0, r_dlen};
        end else begin
            rd_sum = {1'b0, r_wp} + DEPTH_X - {1'b0, r_dlen};
        end
    end

    // multipliers
    logic                   dry_done, fb_done, wet_done;
    logic signed [SAMPLE_W+1:0] dry_scaled;
    logic signed [SB+1:0]   fb_scaled;
    logic signed [SB+2:0]   wet_scaled;
    logic                   dry_half, fb_half, wet_half;
    logic signed [SB:0]     diff;

    assign diff = (SB+1)'(r_dly) - (SB+1)'(r_dry);

    sfd_sermul #(.MW(SAMPLE_W)) u_mul_dry (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (dry_go),
        .i_mcand  (r_ch ? r_x_r : r_x_l),
        .i_mult   (r_input_gain),
        .o_done   (dry_done),
        .o_scaled (dry_scaled),
        .o_half   (dry_half)
    );

    sfd_sermul #(.MW(SB)) u_mul_fb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (echo_go),
        .i_mcand  (r_dly),
        .i_mult   ({1'b0, r_feedback_gain}),
        .o_done   (fb_done),
        .o_scaled (fb_scaled),
        .o_half   (fb_half)
    );

    sfd_sermul #(.MW(SB+1)) u_mul_wet (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (echo_go),
        .i_mcand  (diff),
        .i_mult   (r_wet_mix),
        .o_done   (wet_done),
        .o_scaled (wet_scaled),
        .o_half   (wet_half)
    );

    // rounding half carried in as the add's low bit
    logic signed [CLW-1:0] dry_sum, store_sum, mix_sum, mix_ext;
    logic signed [SB-1:0]  dry_clip, store_clip, mix_clip;
    logic [SAMPLE_W-1:0]   mix_out;

    always_comb begin
        dry_sum    = CLW'(dry_scaled) + CLW'(dry_half);
        store_sum  = CLW'(r_dry) + CLW'(fb_scaled) + CLW'(fb_half);
        mix_sum    = CLW'(r_dry) + CLW'(wet_scaled) + CLW'(wet_half);
        dry_clip   = clip_sample(dry_sum);
        store_clip = clip_sample(store_sum);
        mix_clip   = clip_sample(mix_sum);
        mix_ext    = CLW'(mix_clip);
        mix_out    = mix_ext[SAMPLE_W-1:0];
    end

    // echo store: {pointer, channel}
    logic [AW-1:0] rd_addr, wr_addr;
    generate
        if (NCH > 1) begin : g_stereo
            assign rd_addr = {r_rd_ptr, r_ch};
            assign wr_addr = {r_wp, r_ch};
        end else begin : g_mono
            assign rd_addr = r_rd_ptr;
            assign wr_addr = r_wp;
        end
    endgenerate

    logic [SB-1:0] r_mem [MEM_SIZE];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= store_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        addr_ld  = 1'b0;
        dry_go   = 1'b0;
        mem_rd   = 1'b0;
        dry_ld   = 1'b0;
        echo_go  = 1'b0;
        mem_we   = 1'b0;
        ch_next  = 1'b0;
        send     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                addr_ld = 1'b1;
                n_state = ST_DRY_GO;
            end
            ST_DRY_GO: begin
                dry_go  = 1'b1;
                mem_rd  = 1'b1;
                n_state = ST_DRY_RUN;
            end
            ST_DRY_RUN: begin
                if (dry_done) begin
                    dry_ld  = 1'b1;
                    n_state = ST_ECHO_GO;
                end
            end
            ST_ECHO_GO: begin
                echo_go = 1'b1;
                n_state = ST_ECHO_RUN;
            end
            ST_ECHO_RUN: begin
                if (fb_done && wet_done) begin
                    mem_we = 1'b1;
                    if (r_ch == LAST_CH) begin
                        n_state = ST_SEND;
                    end else begin
                        ch_next = 1'b1;
                        n_state = ST_DRY_GO;
                    end
                end
            end
            ST_SEND: begin
                if (!r_out_valid || i_out_ready) begin
                    send    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready && i_in_valid) begin
                r_ch <= 1'b0;
            end else if (ch_next) begin
                r_ch <= 1'b1;
            end
            if (send) begin
                r_out_valid <= 1'b1;
                if (r_wp == PTR_LAST) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_x_l   <= i_in_data.left_in;
            r_x_r   <= i_in_data.right_in;
            r_dlen  <= dl_clamp[PW-1:0];
            r_res_l <= '0;
            r_res_r <= '0;
        end
        if (addr_ld) begin
            r_rd_ptr <= rd_sum[PW-1:0];
            // entries ahead of the pointer are unwritten until the first wrap
            r_rd_ok  <= r_wrapped || ahead;
        end
        if (dry_ld) begin
            r_dry <= dry_clip;
            r_dly <= r_rd_ok ? r_rdata : '0;
        end
        if (mem_we) begin
            if (r_ch) begin
                r_res_r <= mix_out;
            end else begin
                r_res_l <= mix_out;
            end
        end
        if (send) begin
            r_out_data.left_out  <= r_res_l;
            r_out_data.right_out <= r_res_r;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stereo_feedback_delay. Frames are pushed through
// the input handshake with random gaps; an in-bench echo model predicts each
// mixed output frame on input transfer, and a sink process compares every
// output transfer against the oldest prediction. Register settings change
// between phases while the block is idle, covering the range extremes.
// ----------------------------------------------------------------------------
module tb_top;

    import sfd_pkg::*;

    localparam int DEPTH        = 131072;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASES       = 10;
    localparam int PHASE_FRAMES = 172;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    t_cfg_idx            cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_ready;
    t_frame_in           in_data;
    logic                out_valid;
    logic                out_ready;
    t_frame_out          out_data;

    logic                hold_req;
    logic                rx_quiet;
    bit                  tx_quiet;
    int                  frame_errors;

    // echo model state
    logic [CFG_W-1:0]    delay_reg;
    logic [FB_W-1:0]     fb_reg;
    logic [CFG_W-1:0]    wet_reg;
    logic [CFG_W-1:0]    gain_reg;
    logic [16:0]         wr_ptr;
    logic signed [15:0]  echo_mem [2][DEPTH];
    t_frame_out          mix_queue [$];

    stereo_feedback_delay u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Q0.16 product back to sample scale, nearest with ties upwards
    function automatic longint round_q16(longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic t_frame_out mix_frame(t_frame_in f);
        logic [16:0]   d;
        logic [16:0]   rd;
        longint        smp [2];
        longint        dry;
        longint        dly;
        longint        stored;
        longint        mixed [2];
        t_frame_out    r;
        d = delay_reg;
        // zero behaves as one; 17 bits cannot exceed DEPTH-1
        if (d == '0)
            d = 17'd1;
        rd = wr_ptr - d;
        smp[0] = f.left_in;
        smp[1] = f.right_in;
        for (int c = 0; c < 2; c++) begin
            dry      = clip16(round_q16(smp[c] * longint'(gain_reg)));
            dly      = echo_mem[c][rd];
            stored   = clip16(dry + round_q16(dly * longint'(fb_reg)));
            mixed[c] = clip16(dry + round_q16(longint'(wet_reg) * (dly - dry)));
            echo_mem[c][wr_ptr] = stored[15:0];
        end
        wr_ptr      = wr_ptr + 17'd1;
        r.left_out  = mixed[0][15:0];
        r.right_out = mixed[1][15:0];
        return r;
    endfunction

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 512) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic model_reset();
        delay_reg = DELAY_RST;
        fb_reg    = FB_RST;
        wet_reg   = WET_RST;
        gain_reg  = IGAIN_RST;
        wr_ptr    = '0;
        foreach (echo_mem[c, a])
            echo_mem[c][a] = '0;
    endtask

    task automatic send_frame(logic signed [15:0] left, logic signed [15:0] right);
        int         gap;
        t_frame_in  f;
        f.left_in  = left;
        f.right_in = right;
        gap = draw_wait(tx_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= f;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        mix_queue.push_back(mix_frame(f));
    endtask

    // lower valid and let every outstanding frame come out
    task automatic drain_frames();
        if (in_valid)
            in_valid <= 1'b0;
        while (mix_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_DELAY_LENGTH:  delay_reg = value;
            CFG_FEEDBACK_GAIN: fb_reg    = value[FB_W-1:0];
            CFG_WET_MIX:       wet_reg   = value;
            CFG_INPUT_GAIN:    gain_reg  = value;
            default: ;
        endcase
    endtask

    task automatic write_regs(int delay, int fb, int wet, int gain);
        drain_frames();
        put_reg(CFG_DELAY_LENGTH, CFG_W'(delay));
        put_reg(CFG_FEEDBACK_GAIN, CFG_W'(fb));
        put_reg(CFG_WET_MIX, CFG_W'(wet));
        put_reg(CFG_INPUT_GAIN, CFG_W'(gain));
        cfg_we <= 1'b0;
    endtask

    task automatic rand_regs();
        int delay;
        int fb;
        int wet;
        int gain;
        case ($urandom_range(0, 9))
            0: delay = 0;
            1: delay = 131071;
            2: delay = $urandom_range(0, 131071);
            default: delay = $urandom_range(1, 48);
        endcase
        case ($urandom_range(0, 7))
            0: fb = 0;
            1: fb = 65535;
            2: fb = 3277;
            3: fb = 62259;
            default: fb = $urandom_range(3277, 62259);
        endcase
        case ($urandom_range(0, 5))
            0: wet = 0;
            1: wet = 65536;
            2: wet = $urandom_range(65537, 131071);
            default: wet = $urandom_range(0, 65536);
        endcase
        case ($urandom_range(0, 5))
            0: gain = 0;
            1: gain = 65536;
            2: gain = $urandom_range(65537, 131071);
            default: gain = $urandom_range(0, 65536);
        endcase
        write_regs(delay, fb, wet, gain);
    endtask

    // reset settings: long delay, so only the dry half of the mix shows
    task automatic test_default_frames();
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sh0000, 16'sh0000);
        send_frame(-16'sd1, 16'sd1);
        send_frame(16'sh5555, 16'shAAAA);
        send_frame(16'sd1, -16'sd1);
    endtask

    // zero delay acts as one sample; strong feedback drives the store into clipping
    task automatic test_short_delay();
        write_regs(0, 65535, 65536, 65536);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(16'sh0000, 16'sh0000);
        send_frame(16'sh4000, -16'sh4000);
    endtask

    // gains above unity with the longest delay: reads of fresh store, saturating mix
    task automatic test_gain_overdrive();
        write_regs(131071, 0, 131071, 131071);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh2000, -16'sh2000);
        send_frame(16'sh8000, 16'sh7FFF);
        send_frame(-16'sd1, 16'sd1);
    endtask

    task automatic test_zero_gains();
        write_regs(2, 3277, 0, 0);
        send_frame(16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh7FFF);
        write_regs(1, 62259, 65536, 32768);
        send_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(16'sh8000, 16'sh8000);
    endtask

    // sink holds off for a long stretch while frames keep coming
    task automatic test_backpressure();
        write_regs(3, 40000, 40000, 65536);
        tx_quiet = 1'b1;
        hold_req <= 1'b1;
        repeat (12) send_frame(rand_sample(), rand_sample());
        hold_req <= 1'b0;
        tx_quiet = 1'b0;
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++) begin
            rand_regs();
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if (n % 43 == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet <= ($urandom_range(0, 3) == 0);
                end
                send_frame(rand_sample(), rand_sample());
            end
        end
    endtask

    initial begin : result_sink
        int          stall_left;
        bit          hold_seen;
        t_frame_out  want;
        stall_left = 0;
        hold_seen  = 1'b0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (out_valid && out_ready) begin
                    if (mix_queue.size() == 0) begin
                        $error("output transfer with nothing outstanding: %h", out_data);
                        frame_errors++;
                    end else begin
                        want = mix_queue.pop_front();
                        if (out_data.left_out !== want.left_out) begin
                            $error("left_out: expected %0d, got %0d",
                                   want.left_out, out_data.left_out);
                            frame_errors++;
                        end
                        if (out_data.right_out !== want.right_out) begin
                            $error("right_out: expected %0d, got %0d",
                                   want.right_out, out_data.right_out);
                            frame_errors++;
                        end
                    end
                    stall_left = draw_wait(rx_quiet);
                end else if (stall_left > 0) begin
                    stall_left--;
                end
                if (hold_req && !hold_seen) begin
                    stall_left = HOLD_CYCLES;
                    hold_seen  = 1'b1;
                end else if (!hold_req) begin
                    hold_seen = 1'b0;
                end
                out_ready <= (stall_left == 0);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        frame_errors = 0;
        tx_quiet     = 1'b0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_DELAY_LENGTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        hold_req  <= 1'b0;
        rx_quiet  <= 1'b0;
        model_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_default_frames();
        test_short_delay();
        test_gain_overdrive();
        test_zero_gains();
        test_backpressure();
        test_random_phases();

        drain_frames();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (frame_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
